// ===== rtl/bole_pkg.sv =====
// shared types, constants and helpers for the ordered list engine
// no dependencies
package bole_pkg;

  localparam int CAPACITY  = 16;
  localparam int MAX_ITEM  = 15;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int ITEM_W    = 4;
  localparam int TABLE_W   = 8;
  localparam int POS_W     = 5;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int CLASS_W   = 2;
  localparam int QDEPTH    = 2;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_POS  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ITEM_BAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POS_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic [CLASS_W-1:0] CLS_NONE = 2'd3;

  typedef enum logic [1:0] {OP_NONE, OP_INS, OP_REM, OP_CLEAR} op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [COUNT_W-1:0]  steps;  // link hops from head to predecessor
    logic                at_head;
    logic [ITEM_W-1:0]   item;
    logic [TABLE_W-1:0]  table_id;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   item;
    logic [TABLE_W-1:0]  table_id;
    logic [CLASS_W-1:0]  course;
    logic [COUNT_W-1:0]  count;
  } res_t;

  function automatic logic [CLASS_W-1:0] course_of(input logic [ITEM_W-1:0] it);
    if (it >= 1 && it <= 5) return 2'd0;
    else if (it >= 6 && it <= 10) return 2'd1;
    else if (it >= 11 && it <= 15) return 2'd2;
    else return CLS_NONE;
  endfunction

endpackage

// ===== rtl/bounded_ordered_list_engine_top.sv =====
// top level of the ordered list engine: front end, command queue, back end
// depends on bole_pkg, bole_front, bole_cmd_fifo, bole_back
//
// Queue-style ports on both sides. A request is checked in the front end in
// the cycle it is pushed and queued; the back end walks the link chain one
// slot per cycle to the predecessor, then an insert links in a free slot and a
// remove unlinks its victim and then frees it; head requests skip the walk, and
// rejected requests and unused codes are answered as they are popped. After
// reset and after a clear the back end rebuilds the free chain over all
// CAPACITY slots, during which queued requests wait. The walk over the single
// link store sets rate; a new command is taken only when the last is done.
module bounded_ordered_list_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [bole_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bole_pkg::POS_W-1:0]    in_position,
  input  logic [bole_pkg::ITEM_W-1:0]   in_menu_item,
  input  logic [bole_pkg::TABLE_W-1:0]  in_table_id,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bole_pkg::STATUS_W-1:0] out_status,
  output logic [bole_pkg::ITEM_W-1:0]   out_entry_item,
  output logic [bole_pkg::TABLE_W-1:0]  out_entry_table,
  output logic [bole_pkg::CLASS_W-1:0]  out_course_class,
  output logic [bole_pkg::COUNT_W-1:0]  out_entry_count
);
  import bole_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty, front_busy;
  cmd_t cmd_in, cmd_out;
  res_t res;

  bole_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_position,
    .in_menu_item, .in_table_id,
    .cmd_full(cmd_full), .cmd_push(cmd_push), .cmd_data(cmd_in), .busy(front_busy)
  );

  bole_cmd_fifo u_fifo (
    .clk, .rst_n, .wr_en(cmd_push), .wr_data(cmd_in), .full(cmd_full),
    .rd_en(cmd_pop), .rd_data(cmd_out), .empty(cmd_empty)
  );

  bole_back u_back (
    .clk, .rst_n, .cmd_empty(cmd_empty), .cmd_data(cmd_out), .cmd_pop(cmd_pop),
    .out_empty, .out_pop, .res(res)
  );

  assign out_status       = res.status;
  assign out_entry_item   = res.item;
  assign out_entry_table  = res.table_id;
  assign out_course_class = res.course;
  assign out_entry_count  = res.count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_entry_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> (out_entry_item == '0 &&
      out_course_class == CLS_NONE))
    else $error("failed request reports an entry");
  a_no_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");
  a_front_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !front_busy)
    else $error("front end busy");
`endif

endmodule

// ===== rtl/bole_front.sv =====
// front end: accepts requests, checks them against the tracked count and
// queues a command for the back end for each of them; uses bole_pkg
module bole_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [bole_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bole_pkg::POS_W-1:0]    in_position,
  input  logic [bole_pkg::ITEM_W-1:0]   in_menu_item,
  input  logic [bole_pkg::TABLE_W-1:0]  in_table_id,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output bole_pkg::cmd_t                cmd_data,
  output logic                          busy
);
  import bole_pkg::*;

  // count as it will stand after all queued work; front owns it
  logic [COUNT_W-1:0] count_r, count_nxt;
  cmd_t               c;
  logic               ins, rem, pos_bad;
  logic [COUNT_W-1:0] pos_ext;

  assign in_full = cmd_full;
  assign busy    = 1'b0;
  assign pos_ext = COUNT_W'(in_position);

  always_comb begin
    ins     = 1'b0;
    rem     = 1'b0;
    pos_bad = 1'b0;
    c.op       = OP_NONE;
    c.steps    = '0;
    c.at_head  = 1'b1;
    c.item     = in_menu_item;
    c.table_id = in_table_id;
    count_nxt  = count_r;
    case (in_req_type)
      REQ_INS_HEAD: ins = 1'b1;
      REQ_INS_TAIL: begin
        ins = 1'b1;
        c.at_head = (count_r == '0);
        c.steps   = count_r - COUNT_W'(1);
      end
      REQ_INS_POS: begin
        ins = 1'b1;
        if (in_position > 5'd1) begin
          if (pos_ext <= count_r) begin
            c.at_head = 1'b0;
            c.steps   = pos_ext - COUNT_W'(2);
          end else pos_bad = 1'b1;
        end
      end
      REQ_REM_HEAD: rem = 1'b1;
      REQ_REM_TAIL: begin
        rem = 1'b1;
        c.at_head = (count_r <= COUNT_W'(1));
        c.steps   = count_r - COUNT_W'(2);
      end
      REQ_REM_POS: begin
        rem = 1'b1;
        if (in_position > 5'd1) begin
          if (pos_ext <= count_r) begin
            c.at_head = 1'b0;
            c.steps   = pos_ext - COUNT_W'(2);
          end else pos_bad = 1'b1;
        end
      end
      REQ_CLEAR: begin
        c.op = OP_CLEAR;
        count_nxt = '0;
      end
      default: ;
    endcase
    // every request goes through the queue so results stay ordered;
    // failed checks travel as OP_NONE with the status in item
    if (ins) begin
      if (pos_bad) c.item = ITEM_W'(ST_POS_BAD);
      else if (in_menu_item < 1 || 32'(in_menu_item) > MAX_ITEM)
        c.item = ITEM_W'(ST_ITEM_BAD);
      else if (count_r >= COUNT_W'(CAPACITY)) c.item = ITEM_W'(ST_FULL);
      else begin
        c.op = OP_INS;
        count_nxt = count_r + COUNT_W'(1);
      end
    end else if (rem) begin
      if (pos_bad) c.item = ITEM_W'(ST_POS_BAD);
      else if (count_r == '0) c.item = ITEM_W'(ST_EMPTY);
      else begin
        c.op = OP_REM;
        count_nxt = count_r - COUNT_W'(1);
      end
    end else if (c.op == OP_NONE) begin
      c.item = ITEM_W'(ST_OK);
    end
  end

  assign cmd_push = in_push && !cmd_full;
  assign cmd_data = c;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd_push) count_r <= count_nxt;
  end

endmodule

// ===== rtl/bole_cmd_fifo.sv =====
// short command queue between front and back end; uses bole_pkg
module bole_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  bole_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output bole_pkg::cmd_t rd_data,
  output logic           empty
);
  import bole_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t            mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full    = (cnt_r == (PW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= wp_r + PW'(1);
      if (rd_en && !empty) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(wr_en && !full) - (PW+1)'(rd_en && !empty);
    end
  end

endmodule

// ===== rtl/bole_back.sv =====
// back end: walks the link chain and edits the slot store, one hop per cycle;
// holds one finished result in an output register; uses bole_pkg
module bole_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_empty,
  input  bole_pkg::cmd_t           cmd_data,
  output logic                     cmd_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output bole_pkg::res_t           res
);
  import bole_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_EDIT, S_REM2, S_CLR} state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [ITEM_W-1:0]   slot_item_r  [CAPACITY];
  logic [TABLE_W-1:0]  slot_table_r [CAPACITY];
  logic [SLOT_W-1:0]   slot_link_r  [CAPACITY];
  logic [SLOT_W-1:0]   head_r, free_r, cur_r, victim_r;
  logic [COUNT_W-1:0]  hop_r, count_r;
  logic [SLOT_W:0]     clr_r;
  logic                res_v_r;
  res_t                res_r;
  logic                out_free;
  logic                res_set;

  assign out_free  = !res_v_r || out_pop;
  assign out_empty = !res_v_r;
  assign res       = res_r;
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty && out_free;
  // a result word is finished this cycle
  assign res_set   = (cmd_pop && (cmd_data.op == OP_NONE || cmd_data.op == OP_CLEAR)) ||
                     (state_r == S_EDIT && cmd_r.op == OP_INS) || (state_r == S_REM2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      head_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      if (res_set) res_v_r <= 1'b1;
      else if (out_pop) res_v_r <= 1'b0;
      case (state_r)
        // rebuild the free chain, one slot per cycle
        S_CLR: begin
          slot_link_r[clr_r[SLOT_W-1:0]] <= clr_r[SLOT_W-1:0] + SLOT_W'(1);
          clr_r <= clr_r + (SLOT_W+1)'(1);
          if (clr_r == (SLOT_W+1)'(CAPACITY - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cmd_r <= cmd_data;
            cur_r <= head_r;
            hop_r <= '0;
            case (cmd_data.op)
              OP_NONE: begin
                res_r.status   <= STATUS_W'(cmd_data.item);
                res_r.item     <= '0;
                res_r.table_id <= '0;
                res_r.course   <= CLS_NONE;
                res_r.count    <= count_r;
              end
              OP_CLEAR: begin
                res_r.status   <= ST_OK;
                res_r.item     <= '0;
                res_r.table_id <= '0;
                res_r.course   <= CLS_NONE;
                res_r.count    <= '0;
                head_r  <= '0;
                free_r  <= '0;
                count_r <= '0;
                clr_r   <= '0;
                state_r <= S_CLR;
              end
              default: state_r <= cmd_data.at_head ? S_EDIT : S_WALK;
            endcase
          end
        end
        S_WALK: begin
          if (hop_r == cmd_r.steps) state_r <= S_EDIT;
          else begin
            cur_r <= slot_link_r[cur_r];
            hop_r <= hop_r + COUNT_W'(1);
          end
        end
        S_EDIT: begin
          if (cmd_r.op == OP_INS) begin
            slot_item_r[free_r]  <= cmd_r.item;
            slot_table_r[free_r] <= cmd_r.table_id;
            free_r <= slot_link_r[free_r];
            if (cmd_r.at_head) begin
              slot_link_r[free_r] <= head_r;
              head_r <= free_r;
            end else begin
              slot_link_r[free_r] <= slot_link_r[cur_r];
              slot_link_r[cur_r]  <= free_r;
            end
            count_r        <= count_r + COUNT_W'(1);
            res_r.status   <= ST_OK;
            res_r.item     <= cmd_r.item;
            res_r.table_id <= cmd_r.table_id;
            res_r.course   <= course_of(cmd_r.item);
            res_r.count    <= count_r + COUNT_W'(1);
            state_r        <= S_IDLE;
          end else begin
            if (cmd_r.at_head) begin
              victim_r <= head_r;
              head_r   <= slot_link_r[head_r];
            end else begin
              victim_r <= slot_link_r[cur_r];
              slot_link_r[cur_r] <= slot_link_r[slot_link_r[cur_r]];
            end
            state_r <= S_REM2;
          end
        end
        S_REM2: begin
          slot_link_r[victim_r] <= free_r;
          free_r         <= victim_r;
          count_r        <= count_r - COUNT_W'(1);
          res_r.status   <= ST_OK;
          res_r.item     <= slot_item_r[victim_r];
          res_r.table_id <= slot_table_r[victim_r];
          res_r.course   <= course_of(slot_item_r[victim_r]);
          res_r.count    <= count_r - COUNT_W'(1);
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_list_checker.sv =====
// checker for the ordered list engine: watches both word channels,
// predicts each result from its own list model and compares; needs bole_pkg
`timescale 1ns / 100ps
module tb_list_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic [bole_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bole_pkg::POS_W-1:0]    in_position,
  input  logic [bole_pkg::ITEM_W-1:0]   in_menu_item,
  input  logic [bole_pkg::TABLE_W-1:0]  in_table_id,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [bole_pkg::STATUS_W-1:0] out_status,
  input  logic [bole_pkg::ITEM_W-1:0]   out_entry_item,
  input  logic [bole_pkg::TABLE_W-1:0]  out_entry_table,
  input  logic [bole_pkg::CLASS_W-1:0]  out_course_class,
  input  logic [bole_pkg::COUNT_W-1:0]  out_entry_count,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);
  import bole_pkg::*;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    logic [TABLE_W-1:0] tbl;
  } entry_t;

  entry_t      list_q[$];   // list contents, index 0 is the head
  res_t        want_q[$];

  function automatic logic [CLASS_W-1:0] class_of(logic [ITEM_W-1:0] it);
    if (it >= 1 && it <= 5) return 2'd0;
    if (it >= 6 && it <= 10) return 2'd1;
    if (it >= 11 && it <= 15) return 2'd2;
    return CLS_NONE;
  endfunction

  function automatic res_t apply_request(logic [REQ_W-1:0] rq, logic [POS_W-1:0] pos,
                                         logic [ITEM_W-1:0] it, logic [TABLE_W-1:0] tb);
    res_t r;
    int   q;
    bit   ins, rem;
    entry_t e;
    r = '0;
    r.status = ST_OK;
    r.course = CLS_NONE;
    ins = 0; rem = 0; q = 0;
    case (rq)
      REQ_INS_HEAD: begin ins = 1; q = 0; end
      REQ_INS_TAIL: begin ins = 1; q = list_q.size(); end
      REQ_INS_POS: begin
        ins = 1;
        if (pos <= 1) q = 0;
        else if (pos <= list_q.size()) q = pos - 1;
        else r.status = ST_POS_BAD;
      end
      REQ_REM_HEAD: begin rem = 1; q = 0; end
      REQ_REM_TAIL: begin rem = 1; q = list_q.size() - 1; end
      REQ_REM_POS: begin
        rem = 1;
        if (pos <= 1) q = 0;
        else if (pos <= list_q.size()) q = pos - 1;
        else r.status = ST_POS_BAD;
      end
      REQ_CLEAR: list_q.delete();
      default: ;
    endcase
    if (ins && r.status == ST_OK) begin
      if (it < 1 || it > MAX_ITEM) r.status = ST_ITEM_BAD;
      else if (list_q.size() >= CAPACITY) r.status = ST_FULL;
      else begin
        e.item = it; e.tbl = tb;
        list_q.insert(q, e);
        r.item = it; r.table_id = tb; r.course = class_of(it);
      end
    end else if (rem && r.status == ST_OK) begin
      if (list_q.size() == 0) r.status = ST_EMPTY;
      else begin
        e = list_q[q];
        list_q.delete(q);
        r.item = e.item; r.table_id = e.tbl; r.course = class_of(e.item);
      end
    end
    r.count = COUNT_W'(list_q.size());
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      list_q.delete();
      want_q.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        result_count <= result_count + 1;
        if (want_q.size() == 0) begin
          $error("unexpected result word, status %0d", out_status);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (out_status !== w.status || out_entry_item !== w.item ||
              out_entry_table !== w.table_id || out_course_class !== w.course ||
              out_entry_count !== w.count) begin
            if (out_status !== w.status)
              $error("status: expected %0d got %0d", w.status, out_status);
            if (out_entry_item !== w.item)
              $error("entry_item: expected %0d got %0d", w.item, out_entry_item);
            if (out_entry_table !== w.table_id)
              $error("entry_table: expected %0d got %0d", w.table_id, out_entry_table);
            if (out_course_class !== w.course)
              $error("course_class: expected %0d got %0d", w.course, out_course_class);
            if (out_entry_count !== w.count)
              $error("entry_count: expected %0d got %0d", w.count, out_entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full)
        want_q.push_back(apply_request(in_req_type, in_position, in_menu_item, in_table_id));
    end
  end
endmodule

// ===== tb/tb_bounded_ordered_list_engine_top.sv =====
// testbench top for the ordered list engine: clock, reset, request stimulus
// and verdict; depends on bole_pkg, tb_list_checker and the engine rtl
`timescale 1ns / 100ps
module tb_bounded_ordered_list_engine_top;
  import bole_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int STALL_LIMIT  = 4000;

  logic clk = 0, rst_n = 0;
  logic in_push = 0, out_pop = 0;
  logic in_full, out_empty;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [ITEM_W-1:0]   in_menu_item = '0;
  logic [TABLE_W-1:0]  in_table_id = '0;
  logic [STATUS_W-1:0] out_status;
  logic [ITEM_W-1:0]   out_entry_item;
  logic [TABLE_W-1:0]  out_entry_table;
  logic [CLASS_W-1:0]  out_course_class;
  logic [COUNT_W-1:0]  out_entry_count;
  int fail_count, pending, result_count;
  int idle_cycles = 0;
  int sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  bounded_ordered_list_engine_top dut (.*);
  tb_list_checker chk (.*);

  // receiver stall pattern: phases of free popping and of heavy stalling
  int pop_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) pop_mode <= $urandom_range(0, 2);
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      default: out_pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && !((in_push && !in_full) || (out_pop && !out_empty)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d pending", idle_cycles, pending);
      $display("bounded_ordered_list_engine_top: mismatch");
      $finish;
    end
  end

  // drive one word and hold it until accepted
  task automatic send_word(logic [REQ_W-1:0] rq, logic [POS_W-1:0] pos,
                           logic [ITEM_W-1:0] it, logic [TABLE_W-1:0] tb);
    in_push      <= 1'b1;
    in_req_type  <= rq;
    in_position  <= pos;
    in_menu_item <= it;
    in_table_id  <= tb;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_word();
    logic [REQ_W-1:0] rq;
    logic [POS_W-1:0] pos;
    logic [ITEM_W-1:0] it;
    int k;
    k = $urandom_range(0, 99);
    // inserts slightly outnumber removes so the list fills; bias positions within range
    if (k < 45) rq = REQ_W'($urandom_range(0, 2));
    else if (k < 88) rq = REQ_W'($urandom_range(3, 5));
    else if (k < 93) rq = REQ_CLEAR;
    else if (k < 95) rq = REQ_UNUSED;
    else rq = REQ_W'($urandom_range(0, 7));
    pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 31))
                                      : POS_W'($urandom_range(0, 17));
    it  = ($urandom_range(0, 9) == 0) ? 4'd0 : ITEM_W'($urandom_range(1, 15));
    send_word(rq, pos, it, TABLE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int burst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty-list cases, bad items and positions, full list, clear
    send_word(REQ_REM_HEAD, 0, 1, 0);
    send_word(REQ_REM_TAIL, 0, 1, 0);
    send_word(REQ_REM_POS, 1, 1, 0);
    send_word(REQ_REM_POS, 2, 1, 0);
    send_word(REQ_INS_POS, 2, 3, 8'hff);
    send_word(REQ_INS_TAIL, 0, 15, 8'hff);
    send_word(REQ_INS_HEAD, 0, 0, 8'h00);
    send_word(REQ_INS_POS, 31, 0, 8'h11);
    send_word(REQ_INS_POS, 0, 5, 8'h55);
    send_word(REQ_INS_POS, 2, 6, 8'haa);
    send_word(REQ_INS_POS, 1, 10, 8'h01);
    send_word(REQ_INS_POS, 3, 11, 8'h80);
    for (int i = 0; i < 12; i++) send_word(REQ_INS_TAIL, 0, ITEM_W'(i + 1), TABLE_W'(i));
    send_word(REQ_INS_HEAD, 0, 7, 8'h77);
    send_word(REQ_INS_POS, 16, 7, 8'h78);
    send_word(REQ_REM_POS, 16, 0, 0);
    send_word(REQ_REM_POS, 17, 0, 0);
    send_word(REQ_UNUSED, 31, 15, 8'hff);
    send_word(REQ_REM_TAIL, 0, 0, 0);
    send_word(REQ_CLEAR, 0, 0, 0);
    send_word(REQ_INS_TAIL, 0, 9, 8'h99);
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) random_word();
      gap();
    end
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d request words, checked %0d result words", sent, result_count);
    $display("covered every request code, every status, full and empty lists");
    if (fail_count == 0 && pending == 0)
      $display("bounded_ordered_list_engine_top: match");
    else
      $display("bounded_ordered_list_engine_top: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bole_pkg.sv
rtl/bole_front.sv
rtl/bole_cmd_fifo.sv
rtl/bole_back.sv
rtl/bounded_ordered_list_engine_top.sv
tb/tb_list_checker.sv
tb/tb_bounded_ordered_list_engine_top.sv
